/* hdl/eye_image_pixel_compositor_defines.svh */
// Assertion macros for the eye image pixel compositor checker.
// Expects clk and arst_n in the scope of each use.
`ifndef EYE_IMAGE_PIXEL_COMPOSITOR_DEFINES_SVH
`define EYE_IMAGE_PIXEL_COMPOSITOR_DEFINES_SVH

// Same-cycle implication.
`define EIPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EIPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/eipc_pkg.sv */
// Shared types and constants of the eye image pixel compositor.
// No dependencies.
`timescale 1ns / 1ps

package eipc_pkg;

	// word fields
	localparam int TABLE_SEL_W  = 3;
	localparam int TABLE_ADDR_W = 16;
	localparam int TABLE_DATA_W = 16;
	localparam int COORD_W      = 7;
	localparam int PIXEL_W      = 16;
	localparam int LID_W        = 8;

	// func codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// table codes
	localparam logic [TABLE_SEL_W-1:0] SEL_LOWER_LID = 3'd0;
	localparam logic [TABLE_SEL_W-1:0] SEL_UPPER_LID = 3'd1;
	localparam logic [TABLE_SEL_W-1:0] SEL_SCLERA    = 3'd2;
	localparam logic [TABLE_SEL_W-1:0] SEL_POLAR     = 3'd3;
	localparam logic [TABLE_SEL_W-1:0] SEL_IRIS      = 3'd4;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;
	localparam logic [CFG_INDEX_W-1:0] REG_IRIS_SCALE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCLERA_X_OFS   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCLERA_Y_OFS   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LID_THR  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LID_THR  = 3'd4;

	localparam int OFS_W   = 7;
	localparam int THR_W   = 8;
	localparam logic [OFS_W-1:0] SCLERA_OFS_RESET = 7'd36;
	localparam logic [THR_W-1:0] LID_THR_RESET    = 8'd0;

	// iris size derivation
	localparam int IRIS_SCALE_W = 10;
	localparam logic [IRIS_SCALE_W-1:0] IRIS_SCALE_MAX   = 10'd1023;
	localparam int IRIS_SCALE_RESET = 512;
	localparam int LIMIT_W         = 8;
	localparam int LIMIT_MUL_SH    = 7;
	localparam int LIMIT_FRAC_W    = 10;
	localparam int LIMIT_ROUND     = 512;
	localparam int LIM_SUM_W       = LIMIT_FRAC_W + LIMIT_W;
	localparam int IRIS_LIMIT_RESET =
		((1 << LIMIT_MUL_SH) * (1023 - IRIS_SCALE_RESET) + LIMIT_ROUND) >> LIMIT_FRAC_W;
	localparam int IRIS_SCALE_LAST_SHOWN =
		1023 - ((1 << LIMIT_FRAC_W) - LIMIT_ROUND) / (1 << LIMIT_MUL_SH);

	// polar word layout and texture mapping
	localparam int DIST_W        = 7;
	localparam int ANGLE_W       = 9;
	localparam int GAIN_FRAC_W   = 16;
	localparam int GAIN_ONE      = 65536;
	localparam int ANGLE_FRAC_W  = 9;
	localparam int SUM_W         = 8;
	localparam int WIN_W         = 10;

	typedef struct packed {
		logic                    func;
		logic [TABLE_SEL_W-1:0]  table_select;
		logic [TABLE_ADDR_W-1:0] table_address;
		logic [TABLE_DATA_W-1:0] table_data;
	} cmd_t;

endpackage

/* hdl/eipc_in_if.sv */
// Request channel of the eye image pixel compositor.
// Depends on eipc_pkg.
`timescale 1ns / 1ps

interface eipc_in_if;
	import eipc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    func;
	logic [TABLE_SEL_W-1:0]  table_select;
	logic [TABLE_ADDR_W-1:0] table_address;
	logic [TABLE_DATA_W-1:0] table_data;
	logic [COORD_W-1:0]      pixel_x;
	logic [COORD_W-1:0]      pixel_y;

	modport source (output valid, func, table_select, table_address, table_data,
		pixel_x, pixel_y, input ready);
	modport sink (input valid, func, table_select, table_address, table_data,
		pixel_x, pixel_y, output ready);
endinterface

/* hdl/eipc_out_if.sv */
// Result channel of the eye image pixel compositor.
// Depends on eipc_pkg.
`timescale 1ns / 1ps

interface eipc_out_if;
	import eipc_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel_value;

	modport source (output valid, pixel_value, input ready);
	modport sink (input valid, pixel_value, output ready);
endinterface

/* hdl/eipc_ram.sv */
// Single-port RAM with registered read, one access per enabled cycle.
// No dependencies.
`timescale 1ns / 1ps

module eipc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

/* hdl/eipc_iris_div.sv */
// Iris distance limit and texture row gain, derived from the iris scale.
// Gain comes from a restoring divider, one quotient bit per cycle. Depends on eipc_pkg.
`timescale 1ns / 1ps

module eipc_iris_div #(
	parameter int IRIS_TEX_HEIGHT = 80
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [eipc_pkg::IRIS_SCALE_W-1:0]        scale,
	output logic [eipc_pkg::LIMIT_W-1:0]             limit,
	output logic [$clog2(IRIS_TEX_HEIGHT*eipc_pkg::GAIN_ONE+1)-1:0] gain,
	output logic                                     busy
);
	import eipc_pkg::*;

	localparam int GAIN_W = $clog2(IRIS_TEX_HEIGHT*GAIN_ONE+1);
	localparam int CNT_W  = $clog2(GAIN_W);
	localparam logic [GAIN_W-1:0] DIVIDEND   = GAIN_W'(IRIS_TEX_HEIGHT*GAIN_ONE);
	localparam logic [GAIN_W-1:0] GAIN_RESET =
		GAIN_W'(IRIS_TEX_HEIGHT*GAIN_ONE/IRIS_LIMIT_RESET);

	logic [LIM_SUM_W-1:0] lim_sum;
	logic [LIMIT_W-1:0]   limit_next;
	logic [LIMIT_W-1:0]   rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LIMIT_W:0]     trial;
	logic                 take;
	logic [LIMIT_W-1:0]   rem_next;

	assign lim_sum    = (LIM_SUM_W'(IRIS_SCALE_MAX - scale) << LIMIT_MUL_SH)
		+ LIM_SUM_W'(LIMIT_ROUND);
	assign limit_next = lim_sum[LIM_SUM_W-1 -: LIMIT_W];

	assign trial    = {rem_q, DIVIDEND[cnt_q]};
	assign take     = trial >= {1'b0, limit};
	assign rem_next = take ? LIMIT_W'(trial - {1'b0, limit}) : trial[LIMIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit <= LIMIT_W'(IRIS_LIMIT_RESET);
			gain  <= GAIN_RESET;
			busy  <= 1'b0;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (start) begin
			limit <= limit_next;
			gain  <= '0;
			rem_q <= '0;
			cnt_q <= CNT_W'(GAIN_W-1);
			busy  <= limit_next != '0;
		end else if (busy) begin
			rem_q <= rem_next;
			gain  <= {gain[GAIN_W-2:0], take};
			if (cnt_q == '0) begin
				busy <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/eye_image_pixel_compositor.sv */
// Eye image pixel compositor top level: configuration registers and the
// eight-stage pixel pipeline. Depends on eipc_pkg, eipc_in_if, eipc_out_if,
// eipc_ram and eipc_iris_div.
//
// Usage: req carries words; func selects a table word write or a pixel request.
// A table write lands in its image at the stage where that image is read, so
// requests and writes take effect in arrival order. Each pixel request gives
// one word on rsp; writes give none. Throughput is one word per cycle while rsp is
// ready and the gain divider is idle; an accepted pixel passes through the chain lid
// read, polar read, gain multiply, texel address multiply, iris/sclera read, output reg.
// Writing iris_scale starts the gain divider unless the new distance limit is zero:
// req.ready then stays low for one cycle per quotient bit.
// Reset sets the registers to their defaults and empties the pipeline; image
// contents are undefined until loaded. A stalled rsp holds its word; earlier stages
// keep filling bubbles and req.ready drops when all are full or the divider runs.
`timescale 1ns / 1ps

module eye_image_pixel_compositor #(
	parameter int SCREEN_SIZE     = 128,
	parameter int SCLERA_SIZE     = 200,
	parameter int IRIS_SIZE       = 80,
	parameter int IRIS_TEX_WIDTH  = 512,
	parameter int IRIS_TEX_HEIGHT = 80
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [eipc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [eipc_pkg::CFG_DATA_W-1:0]    cfg_data,
	eipc_in_if.sink                            req,
	eipc_out_if.source                         rsp
);
	import eipc_pkg::*;

	localparam int LID_DEPTH    = SCREEN_SIZE * SCREEN_SIZE;
	localparam int SCLERA_DEPTH = SCLERA_SIZE * SCLERA_SIZE;
	localparam int POLAR_DEPTH  = IRIS_SIZE * IRIS_SIZE;
	localparam int IRIS_DEPTH   = IRIS_TEX_WIDTH * IRIS_TEX_HEIGHT;
	localparam int LID_AW       = $clog2(LID_DEPTH);
	localparam int SCLERA_AW    = $clog2(SCLERA_DEPTH);
	localparam int POLAR_AW     = $clog2(POLAR_DEPTH);
	localparam int IRIS_AW      = $clog2(IRIS_DEPTH);
	localparam int IRIS_XW      = $clog2(IRIS_TEX_WIDTH);
	localparam int GAIN_W       = $clog2(IRIS_TEX_HEIGHT*GAIN_ONE+1);
	localparam int PROD_W       = DIST_W + GAIN_W;
	localparam int ROW_W        = PROD_W - GAIN_FRAC_W;
	localparam int WIN_OFF      = (SCLERA_SIZE - IRIS_SIZE) / 2;

	// configuration
	logic [OFS_W-1:0] xofs_q, yofs_q;
	logic [THR_W-1:0] upper_thr_q, lower_thr_q;
	logic [LIMIT_W-1:0] limit;
	logic [GAIN_W-1:0]  gain;
	logic               div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xofs_q      <= SCLERA_OFS_RESET;
			yofs_q      <= SCLERA_OFS_RESET;
			upper_thr_q <= LID_THR_RESET;
			lower_thr_q <= LID_THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCLERA_X_OFS:  xofs_q      <= cfg_data[OFS_W-1:0];
				REG_SCLERA_Y_OFS:  yofs_q      <= cfg_data[OFS_W-1:0];
				REG_UPPER_LID_THR: upper_thr_q <= cfg_data[THR_W-1:0];
				REG_LOWER_LID_THR: lower_thr_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	eipc_iris_div #(
		.IRIS_TEX_HEIGHT(IRIS_TEX_HEIGHT)
	) u_iris_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we && (cfg_index == REG_IRIS_SCALE)),
		.scale  (cfg_data[IRIS_SCALE_W-1:0]),
		.limit  (limit),
		.gain   (gain),
		.busy   (div_busy)
	);

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;
	logic func_s7, on_s7, sc_ok_s7, covered_s7, iris_s7, row_ok_s7;

	assign en_s8 = !v_s8 || rsp.ready;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign req.ready = en_s1 && !div_busy;
	assign rsp.valid = v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid && req.ready;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7 && (func_s7 == FUNC_PIXEL);
		end
	end

	// stage 1: input register
	cmd_t               cmd_s1;
	logic [COORD_W-1:0] x_s1, y_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1 <= '{func: req.func, table_select: req.table_select,
				table_address: req.table_address, table_data: req.table_data};
			x_s1   <= req.pixel_x;
			y_s1   <= req.pixel_y;
		end
	end

	// stage 2: screen check, lid address, sclera coordinates
	cmd_t              cmd_s2;
	logic              on_s2;
	logic [LID_AW-1:0] lid_addr_s2;
	logic [SUM_W-1:0]  sx_s2, sy_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cmd_s2      <= cmd_s1;
			on_s2       <= (32'(x_s1) < SCREEN_SIZE) && (32'(y_s1) < SCREEN_SIZE);
			lid_addr_s2 <= (cmd_s1.func == FUNC_WRITE) ? LID_AW'(cmd_s1.table_address)
				: LID_AW'(32'(y_s1) * SCREEN_SIZE + 32'(x_s1));
			sx_s2       <= {1'b0, xofs_q} + {1'b0, x_s1};
			sy_s2       <= {1'b0, yofs_q} + {1'b0, y_s1};
		end
	end

	logic             lid_we_ok;
	logic [LID_W-1:0] lo_rd, up_rd;

	assign lid_we_ok = v_s2 && (cmd_s2.func == FUNC_WRITE)
		&& (32'(cmd_s2.table_address) < LID_DEPTH);

	eipc_ram #(.WIDTH(LID_W), .DEPTH(LID_DEPTH)) u_lower_lid (
		.clk   (clk),
		.en    (en_s3 && v_s2),
		.we    (lid_we_ok && (cmd_s2.table_select == SEL_LOWER_LID)),
		.addr  (lid_addr_s2),
		.wdata (cmd_s2.table_data[LID_W-1:0]),
		.rdata (lo_rd)
	);

	eipc_ram #(.WIDTH(LID_W), .DEPTH(LID_DEPTH)) u_upper_lid (
		.clk   (clk),
		.en    (en_s3 && v_s2),
		.we    (lid_we_ok && (cmd_s2.table_select == SEL_UPPER_LID)),
		.addr  (lid_addr_s2),
		.wdata (cmd_s2.table_data[LID_W-1:0]),
		.rdata (up_rd)
	);

	// stage 3: iris window, polar and sclera addresses
	logic signed [WIN_W-1:0] ix_c, iy_c;
	logic                    win_c;

	assign ix_c  = $signed({2'b00, sx_s2}) - WIN_W'(WIN_OFF);
	assign iy_c  = $signed({2'b00, sy_s2}) - WIN_W'(WIN_OFF);
	assign win_c = !ix_c[WIN_W-1] && !iy_c[WIN_W-1]
		&& (int'(ix_c) < IRIS_SIZE) && (int'(iy_c) < IRIS_SIZE);

	cmd_t                 cmd_s3;
	logic                 on_s3, win_s3, sc_ok_s3;
	logic [POLAR_AW-1:0]  polar_addr_s3;
	logic [SCLERA_AW-1:0] sc_addr_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cmd_s3        <= cmd_s2;
			on_s3         <= on_s2;
			win_s3        <= win_c;
			polar_addr_s3 <= (cmd_s2.func == FUNC_WRITE) ? POLAR_AW'(cmd_s2.table_address)
				: POLAR_AW'(32'(iy_c) * IRIS_SIZE + 32'(ix_c));
			sc_addr_s3    <= SCLERA_AW'(32'(sy_s2) * SCLERA_SIZE + 32'(sx_s2));
			sc_ok_s3      <= (32'(sx_s2) < SCLERA_SIZE) && (32'(sy_s2) < SCLERA_SIZE);
		end
	end

	logic [TABLE_DATA_W-1:0] polar_rd;

	eipc_ram #(.WIDTH(TABLE_DATA_W), .DEPTH(POLAR_DEPTH)) u_polar (
		.clk   (clk),
		.en    (en_s4 && v_s3),
		.we    (v_s3 && (cmd_s3.func == FUNC_WRITE) && (cmd_s3.table_select == SEL_POLAR)
			&& (32'(cmd_s3.table_address) < POLAR_DEPTH)),
		.addr  (polar_addr_s3),
		.wdata (cmd_s3.table_data),
		.rdata (polar_rd)
	);

	// stage 4: lid cover test
	cmd_t                 cmd_s4;
	logic                 on_s4, win_s4, sc_ok_s4, covered_s4;
	logic [SCLERA_AW-1:0] sc_addr_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			cmd_s4     <= cmd_s3;
			on_s4      <= on_s3;
			win_s4     <= win_s3;
			sc_ok_s4   <= sc_ok_s3;
			sc_addr_s4 <= sc_addr_s3;
			covered_s4 <= (lo_rd <= lower_thr_q) || (up_rd <= upper_thr_q);
		end
	end

	// stage 5: distance limit test, row gain multiply, angle scaling
	logic [DIST_W-1:0]  dist_c;
	logic [ANGLE_W-1:0] angle_c;

	assign dist_c  = polar_rd[DIST_W-1:0];
	assign angle_c = polar_rd[TABLE_DATA_W-1 -: ANGLE_W];

	cmd_t                 cmd_s5;
	logic                 on_s5, sc_ok_s5, covered_s5, iris_s5;
	logic [SCLERA_AW-1:0] sc_addr_s5;
	logic [PROD_W-1:0]    prod_s5;
	logic [IRIS_XW-1:0]   ang_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			cmd_s5     <= cmd_s4;
			on_s5      <= on_s4;
			sc_ok_s5   <= sc_ok_s4;
			covered_s5 <= covered_s4;
			sc_addr_s5 <= sc_addr_s4;
			iris_s5    <= win_s4 && ({1'b0, dist_c} < limit);
			prod_s5    <= PROD_W'(dist_c) * PROD_W'(gain);
			ang_s5     <= IRIS_XW'((32'(angle_c) * IRIS_TEX_WIDTH) >> ANGLE_FRAC_W);
		end
	end

	// stage 6: texel address
	logic [ROW_W-1:0] row_c;

	assign row_c = prod_s5[PROD_W-1:GAIN_FRAC_W];

	cmd_t                 cmd_s6;
	logic                 on_s6, sc_ok_s6, covered_s6, iris_s6, row_ok_s6;
	logic [SCLERA_AW-1:0] sc_addr_s6;
	logic [IRIS_AW-1:0]   iris_addr_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			cmd_s6       <= cmd_s5;
			on_s6        <= on_s5;
			sc_ok_s6     <= sc_ok_s5;
			covered_s6   <= covered_s5;
			iris_s6      <= iris_s5;
			row_ok_s6    <= 32'(row_c) < IRIS_TEX_HEIGHT;
			sc_addr_s6   <= (cmd_s5.func == FUNC_WRITE) ? SCLERA_AW'(cmd_s5.table_address)
				: sc_addr_s5;
			iris_addr_s6 <= (cmd_s5.func == FUNC_WRITE) ? IRIS_AW'(cmd_s5.table_address)
				: IRIS_AW'(32'(row_c) * IRIS_TEX_WIDTH + 32'(ang_s5));
		end
	end

	logic [PIXEL_W-1:0] sclera_rd, iris_rd;

	eipc_ram #(.WIDTH(PIXEL_W), .DEPTH(SCLERA_DEPTH)) u_sclera (
		.clk   (clk),
		.en    (en_s7 && v_s6),
		.we    (v_s6 && (cmd_s6.func == FUNC_WRITE) && (cmd_s6.table_select == SEL_SCLERA)
			&& (32'(cmd_s6.table_address) < SCLERA_DEPTH)),
		.addr  (sc_addr_s6),
		.wdata (cmd_s6.table_data),
		.rdata (sclera_rd)
	);

	eipc_ram #(.WIDTH(PIXEL_W), .DEPTH(IRIS_DEPTH)) u_iris (
		.clk   (clk),
		.en    (en_s7 && v_s6),
		.we    (v_s6 && (cmd_s6.func == FUNC_WRITE) && (cmd_s6.table_select == SEL_IRIS)
			&& (32'(cmd_s6.table_address) < IRIS_DEPTH)),
		.addr  (iris_addr_s6),
		.wdata (cmd_s6.table_data),
		.rdata (iris_rd)
	);

	// stage 7: image reads land
	always_ff @(posedge clk) begin
		if (en_s7) begin
			func_s7    <= cmd_s6.func;
			on_s7      <= on_s6;
			sc_ok_s7   <= sc_ok_s6;
			covered_s7 <= covered_s6;
			iris_s7    <= iris_s6;
			row_ok_s7  <= row_ok_s6;
		end
	end

	// stage 8: output register
	logic [PIXEL_W-1:0] pixel_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			if (!on_s7 || covered_s7) begin
				pixel_s8 <= '0;
			end else if (iris_s7) begin
				pixel_s8 <= row_ok_s7 ? iris_rd : '0;
			end else begin
				pixel_s8 <= sc_ok_s7 ? sclera_rd : '0;
			end
		end
	end

	assign rsp.pixel_value = pixel_s8;

endmodule

/* hdl/eipc_checker.sv */
// Port-level checks of the eye image pixel compositor, bound to the top level.
// Depends on eipc_pkg and eye_image_pixel_compositor_defines.svh.
`timescale 1ns / 1ps
`include "eye_image_pixel_compositor_defines.svh"

module eipc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [eipc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [eipc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [eipc_pkg::PIXEL_W-1:0]     pixel_value
);
	import eipc_pkg::*;

	`EIPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")
	`EIPC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(pixel_value), "rsp word changed while stalled")
	`EIPC_ASSERT_NEXT(a_div_blocks, cfg_we && (cfg_index == REG_IRIS_SCALE) && (cfg_data <= CFG_DATA_W'(IRIS_SCALE_LAST_SHOWN)), !req_ready, "req accepted while gain divider runs")
	`EIPC_ASSERT_NOW(a_empty_after_reset, !$past(arst_n), !rsp_valid, "rsp word right after reset")

endmodule

bind eye_image_pixel_compositor eipc_checker u_eipc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index),
	.cfg_data    (cfg_data),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.pixel_value (rsp.pixel_value)
);
